### rtl/core/dlr_pkg.sv
// dlr_pkg: shared constants and types for the dual level relay switch
// no dependencies; imported by the relay machine, the top level and the checker
package dlr_pkg;

    localparam int LEVEL_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PHASE_W    = 2;
    // 65535 s * 1000 fits in 26 bits
    localparam int DELAY_MS_W = 26;

    localparam int unsigned MS_PER_SEC = 1000;

    localparam logic [PHASE_W-1:0] PH_OFF      = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ARMING   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ON       = 2'd2;
    localparam logic [PHASE_W-1:0] PH_CLEARING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLR_DELAY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 3'd6;

    localparam logic [LEVEL_W-1:0]    RST_LEVEL_ONE = 16'd1000;
    localparam logic [LEVEL_W-1:0]    RST_LEVEL_TWO = 16'd2000;
    localparam logic [LEVEL_W-1:0]    RST_HYST      = 16'd50;
    localparam logic [DELAY_MS_W-1:0] RST_DELAY_MS  = 26'd5000;

    // per-relay settings as seen by one machine
    typedef struct packed {
        logic [LEVEL_W-1:0]    threshold;
        logic [LEVEL_W-1:0]    clear_level;
        logic [DELAY_MS_W-1:0] trigger_ms;
        logic [DELAY_MS_W-1:0] clear_ms;
    } relay_cfg_t;

endpackage

### rtl/core/dlr_relay.sv
// dlr_relay: four-phase on/off delay machine for one relay
// depends on dlr_pkg; holds phase, start timestamp and on flag
module dlr_relay
    import dlr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [LEVEL_W-1:0]  level,
    input  logic [TIME_W-1:0]   now,
    input  relay_cfg_t          cfg,
    output logic [PHASE_W-1:0]  phase_next,
    output logic                on_next
);

    logic [PHASE_W-1:0] phase_reg;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  start_next;
    logic               on_reg;
    logic [TIME_W-1:0]  elapsed;
    logic               trig_done;
    logic               clr_done;

    // wrapping difference of timestamps
    assign elapsed   = now - start_reg;
    assign trig_done = elapsed >= TIME_W'(cfg.trigger_ms);
    assign clr_done  = elapsed >= TIME_W'(cfg.clear_ms);

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        on_next    = on_reg;
        if (step)
        begin
            case (phase_reg)
                PH_OFF:
                begin
                    if (level >= cfg.threshold)
                    begin
                        phase_next = PH_ARMING;
                        start_next = now;
                    end
                end
                PH_ARMING:
                begin
                    if (level < cfg.threshold)
                    begin
                        phase_next = PH_OFF;
                    end
                    else if (trig_done)
                    begin
                        phase_next = PH_ON;
                        on_next    = 1'b1;
                    end
                end
                PH_ON:
                begin
                    if (level < cfg.clear_level)
                    begin
                        phase_next = PH_CLEARING;
                        start_next = now;
                    end
                end
                default:
                begin
                    if (level >= cfg.clear_level)
                    begin
                        phase_next = PH_ON;
                    end
                    else if (clr_done)
                    begin
                        phase_next = PH_OFF;
                        on_next    = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OFF;
            start_reg <= '0;
            on_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            on_reg    <= on_next;
        end
    end

endmodule

### rtl/core/dual_level_relay_delay_hysteresis.sv
// two-relay level switch: input register, two dlr_relay machines, result register; needs dlr_pkg
// a sample passes from the input register to the result register; one sample accepted per
// cycle when the result side does not stall
// a stalled result stalls the input only once the input register also holds a sample
// reset clears both machines to off, the start times and on flags to zero,
// and loads the configuration registers with their default values
module dual_level_relay_delay_hysteresis
    import dlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEVEL_W-1:0]    water_level,
    input  logic                  sample_valid,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  relay_one_on,
    output logic                  relay_two_on,
    output logic                  relay_one_pin,
    output logic                  relay_two_pin,
    output logic [PHASE_W-1:0]    relay_one_phase,
    output logic [PHASE_W-1:0]    relay_two_phase,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LEVEL_W-1:0]    level_one_reg;
    logic [LEVEL_W-1:0]    level_two_reg;
    logic [LEVEL_W-1:0]    hyst_one_reg;
    logic [LEVEL_W-1:0]    hyst_two_reg;
    logic [DELAY_MS_W-1:0] trig_ms_reg;
    logic [DELAY_MS_W-1:0] clr_ms_reg;
    logic                  active_low_reg;
    logic [DELAY_MS_W-1:0] cfg_ms;

    logic                  s1_valid_reg;
    logic [LEVEL_W-1:0]    s1_level_reg;
    logic                  s1_sample_reg;
    logic [TIME_W-1:0]     s1_now_reg;

    logic                  out_valid_reg;
    logic                  on_one_reg;
    logic                  on_two_reg;
    logic                  pin_one_reg;
    logic                  pin_two_reg;
    logic [PHASE_W-1:0]    phase_one_reg;
    logic [PHASE_W-1:0]    phase_two_reg;

    logic                  advance;
    logic                  step;
    relay_cfg_t            cfg_one;
    relay_cfg_t            cfg_two;
    logic [PHASE_W-1:0]    phase_one_next;
    logic [PHASE_W-1:0]    phase_two_next;
    logic                  on_one_next;
    logic                  on_two_next;

    // configuration port, delays kept in milliseconds
    assign cfg_ready = 1'b1;
    assign cfg_ms    = DELAY_MS_W'(cfg_data) * DELAY_MS_W'(MS_PER_SEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_one_reg  <= RST_LEVEL_ONE;
            level_two_reg  <= RST_LEVEL_TWO;
            hyst_one_reg   <= RST_HYST;
            hyst_two_reg   <= RST_HYST;
            trig_ms_reg    <= RST_DELAY_MS;
            clr_ms_reg     <= RST_DELAY_MS;
            active_low_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEVEL_ONE:  level_one_reg  <= cfg_data;
                REG_LEVEL_TWO:  level_two_reg  <= cfg_data;
                REG_HYST_ONE:   hyst_one_reg   <= cfg_data;
                REG_HYST_TWO:   hyst_two_reg   <= cfg_data;
                REG_TRIG_DELAY: trig_ms_reg    <= cfg_ms;
                REG_CLR_DELAY:  clr_ms_reg     <= cfg_ms;
                REG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // clear level floors at zero
    always_comb
    begin
        cfg_one.threshold   = level_one_reg;
        cfg_one.clear_level = (level_one_reg > hyst_one_reg) ?
                              (level_one_reg - hyst_one_reg) : '0;
        cfg_one.trigger_ms  = trig_ms_reg;
        cfg_one.clear_ms    = clr_ms_reg;
        cfg_two.threshold   = level_two_reg;
        cfg_two.clear_level = (level_two_reg > hyst_two_reg) ?
                              (level_two_reg - hyst_two_reg) : '0;
        cfg_two.trigger_ms  = trig_ms_reg;
        cfg_two.clear_ms    = clr_ms_reg;
    end

    // pipeline control
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign step     = s1_valid_reg && advance && s1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_level_reg  <= water_level;
            s1_sample_reg <= sample_valid;
            s1_now_reg    <= now_ms;
        end
    end

    dlr_relay u_relay_one (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .level      (s1_level_reg),
        .now        (s1_now_reg),
        .cfg        (cfg_one),
        .phase_next (phase_one_next),
        .on_next    (on_one_next)
    );

    dlr_relay u_relay_two (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .level      (s1_level_reg),
        .now        (s1_now_reg),
        .cfg        (cfg_two),
        .phase_next (phase_two_next),
        .on_next    (on_two_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            on_one_reg    <= on_one_next;
            on_two_reg    <= on_two_next;
            pin_one_reg   <= on_one_next ^ active_low_reg;
            pin_two_reg   <= on_two_next ^ active_low_reg;
            phase_one_reg <= phase_one_next;
            phase_two_reg <= phase_two_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign relay_one_on    = on_one_reg;
    assign relay_two_on    = on_two_reg;
    assign relay_one_pin   = pin_one_reg;
    assign relay_two_pin   = pin_two_reg;
    assign relay_one_phase = phase_one_reg;
    assign relay_two_phase = phase_two_reg;

endmodule

### rtl/core/dlr_check.sv
// dlr_check: port-level checks for the dual level relay switch
// depends on dlr_pkg; bound to the top level at the end of this file
module dlr_check
    import dlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               relay_one_on,
    input  logic               relay_two_on,
    input  logic [PHASE_W-1:0] relay_one_phase,
    input  logic [PHASE_W-1:0] relay_two_phase
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(relay_one_phase)
            && $stable(relay_two_phase) && $stable(relay_one_on)
            && $stable(relay_two_on))
        else $error("result changed while stalled");

    // on flag is set exactly in the on and clearing phases
    a_one_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> relay_one_on ==
            (relay_one_phase == PH_ON || relay_one_phase == PH_CLEARING))
        else $error("relay one on flag disagrees with phase");

    a_two_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> relay_two_on ==
            (relay_two_phase == PH_ON || relay_two_phase == PH_CLEARING))
        else $error("relay two on flag disagrees with phase");

endmodule

bind dual_level_relay_delay_hysteresis dlr_check u_dlr_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .relay_one_on    (relay_one_on),
    .relay_two_on    (relay_two_on),
    .relay_one_phase (relay_one_phase),
    .relay_two_phase (relay_two_phase)
);
